// ===== rtl/three_channel_prescaled_timer_assert.svh =====
// assertion macros for the prescaled timer
`ifndef THREE_CHANNEL_PRESCALED_TIMER_ASSERT_SVH
`define THREE_CHANNEL_PRESCALED_TIMER_ASSERT_SVH
// implication checked every clock outside reset
`define TPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define TPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/tpt_pkg.sv =====
//------------------------------------------------------------------------------
// tpt_pkg
// shared types and constants of the prescaled timer
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package tpt_pkg;
   localparam int PRESCALE_BITS_DEFAULT = 12;
   localparam logic [1:0] FUNC_ADVANCE = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_WRITE   = 2'd2;
   localparam logic [1:0] FUNC_NOP     = 2'd3;
   localparam logic [7:0] UNMAPPED_DATA = 8'hCD;
   localparam logic [23:0] CSEL_BASE  = 24'h002018;
   localparam logic [23:0] TIMER_BASE = 24'h002030;
   localparam logic [23:0] TIMER_LAST = 24'h002047;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  func;
      logic [23:0] address;
      logic [7:0]  write_data;
      logic [7:0]  osc1_ticks;
      logic [7:0]  osc3_ticks;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [5:0] irq_raised;
   } rsp_type;

   function automatic logic [3:0] fast_shift(input logic [2:0] r);
      case (r)
         3'd0: fast_shift = 4'd1;
         3'd1: fast_shift = 4'd3;
         3'd2: fast_shift = 4'd5;
         3'd3: fast_shift = 4'd6;
         3'd4: fast_shift = 4'd7;
         3'd5: fast_shift = 4'd8;
         3'd6: fast_shift = 4'd10;
         default: fast_shift = 4'd12;
      endcase
   endfunction
endpackage

// ===== rtl/tpt_channel_if.sv =====
//------------------------------------------------------------------------------
// tpt_channel_if
// valid/ready channel carrying one payload
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tpt_channel_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tpt_queue.sv =====
//------------------------------------------------------------------------------
// tpt_queue
// short fifo between the request front end and the timer engine
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tpt_queue
   import tpt_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) cnt_in = cnt_ff + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   `include "three_channel_prescaled_timer_assert.svh"
   `TPT_ASSERT_IMP(a_count_range, clock, reset, 1'b1, cnt_ff <= (AW+1)'(DEPTH))
   `TPT_ASSERT_NXT(a_push_grows, clock, reset, push && !full && !pop, !empty)
   `TPT_ASSERT_NXT(a_pop_shrinks, clock, reset, pop && !push && cnt_ff == 1, empty)
endmodule

// ===== rtl/tpt_mod_unit.sv =====
//------------------------------------------------------------------------------
// tpt_mod_unit
// iterative remainder, one quotient bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tpt_mod_unit
   import tpt_pkg::*;
#(
   parameter int NW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [16:0]   divisor,
   output logic          done,
   output logic [16:0]   remainder
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] num_ff, num_in;
   logic [17:0]   rem_ff, rem_in;
   logic [16:0]   div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [17:0]   shifted;

   assign done = done_ff;
   assign remainder = rem_ff[16:0];

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[16:0], num_ff[NW-1]};
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = (shifted >= {1'b0, div_ff}) ? shifted - {1'b0, div_ff} : shifted;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
endmodule

// ===== rtl/tpt_engine.sv =====
//------------------------------------------------------------------------------
// tpt_engine
// register file, prescalers and per-half count sequencer
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tpt_engine
   import tpt_pkg::*;
#(
   parameter int PRESCALE_BITS = PRESCALE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  req_type item,
   output logic    item_pop,
   tpt_channel_if.source rsp
);
   localparam int AW = PRESCALE_BITS + 1;
   localparam int XW = (AW > 17) ? AW : 17;
   localparam logic [3:0] S_IDLE = 4'd0, S_SETUP = 4'd1, S_CALC = 4'd2, S_MOD = 4'd3,
                          S_WAITM = 4'd4, S_FIN = 4'd5, S_OUT = 4'd6;

   logic [7:0] lc_ff [3], hc_ff [3], lr_ff [3], hr_ff [3], lm_ff [3], hm_ff [3];
   logic [6:0] fl_ff [3];
   logic [9:0] cs_ff [3];
   logic [1:0] oe_ff;
   logic [PRESCALE_BITS-1:0] sp_ff, fp_ff;

   logic [3:0] st_ff;
   logic       job_ff;
   logic [1:0] t_ff;
   logic [7:0] o1_ff, o3_ff;
   logic [AW-1:0] adv_ff;
   logic [15:0] cnt_ff, per_ff, mat_ff;
   logic [5:0]  irq_ff;
   logic [7:0]  rd_ff;
   logic        under_ff, rsp_valid_ff;

   logic        mod_start, mod_done;
   logic [16:0] mod_rem;

   // job: 0 low/16-bit half, 1 high half, per timer
   logic [6:0] fl;
   logic [9:0] cs;
   logic       sixteen, hi_job, src, en;
   logic [2:0] ratio;
   logic [3:0] sh;
   logic [PRESCALE_BITS-1:0] pre;
   logic [AW-1:0] sum, msk;
   logic [7:0] tk;

   assign fl = fl_ff[t_ff];
   assign cs = cs_ff[t_ff];
   assign sixteen = fl[3];
   assign hi_job = job_ff;
   assign src = hi_job ? cs[9] : cs[8];
   assign en = hi_job ? cs[7] : cs[3];
   assign ratio = hi_job ? cs[6:4] : cs[2:0];
   assign sh = src ? {1'b0, ratio} : fast_shift(ratio);
   assign pre = src ? sp_ff : fp_ff;
   assign tk = src ? o1_ff : o3_ff;
   assign msk = (AW'(1) << sh) - AW'(1);
   assign sum = (AW'(pre) & msk) + AW'(tk);

   tpt_mod_unit #(.NW(AW + 1)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start),
      .dividend((AW+1)'(adv_ff) - (AW+1)'(cnt_ff)),
      .divisor({1'b0, per_ff} + 17'd1), .done(mod_done), .remainder(mod_rem)
   );
   assign mod_start = (st_ff == S_MOD);

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = {rd_ff, irq_ff};
   assign item_pop = (st_ff == S_IDLE) && item_valid && !rsp_valid_ff;

   function automatic logic [7:0] rd_reg(input logic [23:0] a, input logic [6:0] f,
                                         input logic [7:0] v [6]);
      case (a[2:0])
         3'd0: rd_reg = {f[3], 3'b0, f[2], f[1], 1'b0, f[0]};
         3'd1: rd_reg = {4'b0, f[6], f[5], 1'b0, f[4]};
         3'd2: rd_reg = v[0];
         3'd3: rd_reg = v[1];
         3'd4: rd_reg = v[2];
         3'd5: rd_reg = v[3];
         3'd6: rd_reg = v[4];
         default: rd_reg = v[5];
      endcase
   endfunction

   logic        jact;
   logic [16:0] cnt17, per17;
   logic [16:0] dlt;
   logic        hit;
   logic [1:0]  rt;
   logic [7:0]  rv [6];
   logic [23:0] roff;

   assign jact = hi_job ? (!sixteen && fl[5]) : fl[1];
   assign cnt17 = {1'b0, cnt_ff};
   assign per17 = {1'b0, per_ff};
   assign dlt = (cnt17 >= {1'b0, mat_ff}) ? cnt17 - {1'b0, mat_ff}
                                          : cnt17 - {1'b0, mat_ff} + per17 + 17'd1;
   assign hit = (t_ff == 2'd2) && !hi_job && (mat_ff <= per_ff)
                && (XW'(dlt) < XW'(adv_ff));
   assign roff = item.address - TIMER_BASE;
   assign rt = roff[4:3];
   assign rv[0] = lr_ff[rt];
   assign rv[1] = hr_ff[rt];
   assign rv[2] = lm_ff[rt];
   assign rv[3] = hm_ff[rt];
   assign rv[4] = lc_ff[rt];
   assign rv[5] = hc_ff[rt];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         t_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            lc_ff[i] <= '0; hc_ff[i] <= '0; lr_ff[i] <= '0; hr_ff[i] <= '0;
            lm_ff[i] <= '0; hm_ff[i] <= '0; fl_ff[i] <= '0; cs_ff[i] <= '0;
         end
         oe_ff <= '0;
         sp_ff <= '0;
         fp_ff <= '0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (item_pop) begin
                  if (item.func != FUNC_READ) rd_ff <= '0;
                  irq_ff <= '0;
                  t_ff <= '0;
                  job_ff <= 1'b0;
                  o1_ff <= oe_ff[0] ? item.osc1_ticks : '0;
                  o3_ff <= oe_ff[1] ? item.osc3_ticks : '0;
                  if (item.func == FUNC_ADVANCE) st_ff <= S_SETUP;
                  else st_ff <= S_OUT;
                  if (item.func == FUNC_READ) begin
                     if (item.address == CSEL_BASE || item.address == CSEL_BASE + 24'd2
                         || item.address == CSEL_BASE + 24'd4)
                        rd_ff <= cs_ff[2'((item.address - CSEL_BASE) >> 1)][7:0];
                     else if (item.address == CSEL_BASE + 24'd1
                              || item.address == CSEL_BASE + 24'd3
                              || item.address == CSEL_BASE + 24'd5)
                        rd_ff <= {2'b0, (item.address == CSEL_BASE + 24'd1) ?
                                  oe_ff : 2'b0, 2'b0,
                                  cs_ff[2'((item.address - CSEL_BASE) >> 1)][9:8]};
                     else if (item.address < TIMER_BASE || item.address > TIMER_LAST)
                        rd_ff <= UNMAPPED_DATA;
                     else
                        rd_ff <= rd_reg(item.address, fl_ff[rt], rv);
                  end
                  if (item.func == FUNC_WRITE) begin
                     if (item.address == CSEL_BASE || item.address == CSEL_BASE + 24'd2
                         || item.address == CSEL_BASE + 24'd4)
                        cs_ff[2'((item.address - CSEL_BASE) >> 1)][7:0] <= item.write_data;
                     else if (item.address == CSEL_BASE + 24'd1
                              || item.address == CSEL_BASE + 24'd3
                              || item.address == CSEL_BASE + 24'd5) begin
                        cs_ff[2'((item.address - CSEL_BASE) >> 1)][9:8] <= item.write_data[1:0];
                        if (item.address == CSEL_BASE + 24'd1)
                           oe_ff <= {item.write_data[5], item.write_data[4]};
                     end else if (item.address >= TIMER_BASE && item.address <= TIMER_LAST) begin
                        case (item.address[2:0])
                           3'd0: begin
                              fl_ff[rt][3:0] <= {item.write_data[7], item.write_data[3],
                                                 item.write_data[2], item.write_data[0]};
                              if (item.write_data[7] || item.write_data[1]) begin
                                 lc_ff[rt] <= lr_ff[rt];
                                 if (item.write_data[7]) hc_ff[rt] <= hr_ff[rt];
                              end
                           end
                           3'd1: begin
                              fl_ff[rt][6:4] <= {item.write_data[3], item.write_data[2],
                                                 item.write_data[0]};
                              if ((item.write_data[7] || item.write_data[1]) && !fl_ff[rt][3])
                                 hc_ff[rt] <= hr_ff[rt];
                           end
                           3'd2: lr_ff[rt] <= item.write_data;
                           3'd3: hr_ff[rt] <= item.write_data;
                           3'd4: lm_ff[rt] <= item.write_data;
                           3'd5: hm_ff[rt] <= item.write_data;
                           default: ;
                        endcase
                     end
                  end
               end
            end
            S_SETUP: begin
               if (!jact) begin
                  if (job_ff) begin
                     if (t_ff == 2'd2) st_ff <= S_FIN;
                     else t_ff <= t_ff + 2'd1;
                  end
                  job_ff <= ~job_ff;
               end else begin
                  adv_ff <= en ? AW'(sum >> sh) : '0;
                  if (hi_job) begin
                     cnt_ff <= {8'd0, hc_ff[t_ff]};
                     per_ff <= {8'd0, hr_ff[t_ff]};
                     mat_ff <= {8'd0, hm_ff[t_ff]};
                  end else if (sixteen) begin
                     cnt_ff <= {hc_ff[t_ff], lc_ff[t_ff]};
                     per_ff <= {hr_ff[t_ff], lr_ff[t_ff]};
                     mat_ff <= {hm_ff[t_ff], lm_ff[t_ff]};
                  end else begin
                     cnt_ff <= {8'd0, lc_ff[t_ff]};
                     per_ff <= {8'd0, lr_ff[t_ff]};
                     mat_ff <= {8'd0, lm_ff[t_ff]};
                  end
                  st_ff <= S_CALC;
               end
            end
            S_CALC: begin
               if (hit) irq_ff[5] <= 1'b1;
               under_ff <= (XW'(cnt_ff) < XW'(adv_ff));
               if (XW'(cnt_ff) >= XW'(adv_ff)) begin
                  cnt_ff <= 16'(cnt_ff - 16'(adv_ff));
                  st_ff <= S_WAITM;
               end else st_ff <= S_MOD;
            end
            S_MOD: st_ff <= S_WAITM;
            S_WAITM: begin
               if (!under_ff || mod_done) begin : wb
                  logic [15:0] nc;
                  nc = !under_ff ? cnt_ff :
                       (mod_rem == '0) ? 16'd0 : 16'(per17 + 17'd1 - mod_rem);
                  if (under_ff) begin
                     if (hi_job || sixteen) irq_ff[{1'b0, t_ff} * 3'd2 + 3'd1 - ((t_ff == 2'd2) ? 3'd1 : 3'd0)] <= 1'b1;
                     else if (t_ff != 2'd2) irq_ff[{1'b0, t_ff} * 3'd2] <= 1'b1;
                  end
                  if (hi_job) hc_ff[t_ff] <= nc[7:0];
                  else begin
                     lc_ff[t_ff] <= nc[7:0];
                     if (sixteen) hc_ff[t_ff] <= nc[15:8];
                  end
                  if (job_ff) begin
                     if (t_ff == 2'd2) st_ff <= S_FIN;
                     else begin
                        t_ff <= t_ff + 2'd1;
                        st_ff <= S_SETUP;
                     end
                  end else st_ff <= S_SETUP;
                  job_ff <= ~job_ff;
               end
            end
            S_FIN: begin
               sp_ff <= sp_ff + PRESCALE_BITS'(o1_ff);
               fp_ff <= fp_ff + PRESCALE_BITS'(o3_ff);
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `include "three_channel_prescaled_timer_assert.svh"
   `TPT_ASSERT_IMP(a_pop_idle, clock, reset, item_pop, st_ff == S_IDLE)
   `TPT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `TPT_ASSERT_IMP(a_timer_idx, clock, reset, 1'b1, t_ff != 2'd3)
endmodule

// ===== rtl/three_channel_prescaled_timer.sv =====
//------------------------------------------------------------------------------
// three_channel_prescaled_timer
// three 8/16-bit interval timers behind a request/response channel
//------------------------------------------------------------------------------
// Every request transaction yields one response. Requests pass through a
// two-entry queue into a sequencer that handles reads, writes and time
// advances; during an advance each active half runs through a bit-serial
// remainder unit on underflow.
`timescale 1ns / 1ps
module three_channel_prescaled_timer
   import tpt_pkg::*;
#(
   parameter int PRESCALE_BITS = PRESCALE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tpt_channel_if.sink   req,
   tpt_channel_if.source rsp
);
   logic    full, empty, pop;
   req_type head;

   assign req.ready = !full;

   tpt_queue #(.WIDTH($bits(req_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(req.valid), .push_data(req.payload),
      .full(full), .pop(pop), .pop_data(head), .empty(empty)
   );

   tpt_engine #(.PRESCALE_BITS(PRESCALE_BITS)) u_engine (
      .clock(clock), .reset(reset), .item_valid(!empty), .item(head),
      .item_pop(pop), .rsp(rsp)
   );
endmodule
